>>> src/lef_pkg.sv
// ----------------------------------------------------------------------------
// lef_pkg: shared definitions for the 3x3 Laplacian edge filter
// Frame limits, register indexes, field widths and the types passed between
// the window cells, the kernel and the top level.
// ----------------------------------------------------------------------------
package lef_pkg;

  // Frame limits and derived widths.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 3;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);
  localparam int DIM_W      = 11;
  localparam int PIX_W      = 8;
  localparam int IDX_W      = 2;
  localparam int NUM_COLS   = 3;

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;

  // Reset values of the frame size registers.
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

  // Largest clamped result.
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // One window column: the pixel two rows up, one row up and on this row.
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  // Per-beat status that travels down the pipeline.
  typedef struct packed {
    logic emit;
    logic border;
    logic last;
  } flags_t;

  // Clamp a written dimension into the supported range.
  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] top);
    logic [DIM_W-1:0] res;
    if (v < DIM_W'(MIN_DIM)) begin
      res = DIM_W'(MIN_DIM);
    end else if (v > top) begin
      res = top;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

>>> src/lef_ram.sv
// ----------------------------------------------------------------------------
// lef_ram: generic simple dual-port RAM
// One write port and one read port with registered read data. A read and a
// write to the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module lef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/lef_cell.sv
// ----------------------------------------------------------------------------
// lef_cell: one column of the 3x3 window
// Holds three pixels; takes the new or the neighbor's column on every shift.
// ----------------------------------------------------------------------------
module lef_cell
  import lef_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic shift,
  input  col_t col_in,
  output col_t col
);

  // Column register, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

endmodule

>>> src/lef_kernel.sv
// ----------------------------------------------------------------------------
// lef_kernel: Laplacian arithmetic
// Registers two partial sums of the eight neighbors and the center, then
// forms eight times the center minus the neighbors, clamped to 0..255.
// ----------------------------------------------------------------------------
module lef_kernel
  import lef_pkg::*;
(
  input  logic             clk,
  input  logic             load,
  input  col_t             win [NUM_COLS],
  output logic [PIX_W-1:0] centre,
  output logic [PIX_W-1:0] lap
);

  logic [PIX_W+1:0] sum_a;
  logic [PIX_W+1:0] sum_b;
  logic signed [PIX_W+3:0] acc;

  // First step: two sums of four neighbors each.
  always_ff @(posedge clk) begin
    if (load) begin
      sum_a  <= 10'(win[0].top) + 10'(win[1].top) + 10'(win[2].top) + 10'(win[0].mid);
      sum_b  <= 10'(win[2].mid) + 10'(win[0].bot) + 10'(win[1].bot) + 10'(win[2].bot);
      centre <= win[1].mid;
    end
  end

  // Second step: subtract from eight times the center and clamp.
  always_comb begin
    acc = $signed({1'b0, centre, 3'b000}) - $signed({2'b00, sum_a})
          - $signed({2'b00, sum_b});
    if (acc < 0) begin
      lap = '0;
    end else if (acc > $signed({4'b0000, PIX_MAX})) begin
      lap = PIX_MAX;
    end else begin
      lap = acc[PIX_W-1:0];
    end
  end

endmodule

>>> src/laplacian_edge_filter_3x3.sv
// ----------------------------------------------------------------------------
// laplacian_edge_filter_3x3: 3x3 Laplacian edge filter on a raster stream
// A result leaves the output register after the input beat that releases it;
// that beat trails the result's own pixel by image_width+1 beats. Throughput
// is one beat per cycle unless stalled: each line store takes one read and
// one write per beat, and the three window cells shift once per beat. Reset
// clears the frame position, the window and the pipeline. The line stores
// are not cleared; their contents before a write never reach a result.
// ----------------------------------------------------------------------------
module laplacian_edge_filter_3x3
  import lef_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // Pixel input channel.
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [PIX_W-1:0] gray_in,
  input  logic             padding,
  // Result output channel.
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] edge_out,
  output logic             on_border,
  output logic             frame_last,
  // Configuration write port.
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  logic [DIM_W-1:0] img_w;
  logic [DIM_W-1:0] img_h;
  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;

  logic             in_acc;
  logic [PIX_W-1:0] pix;
  flags_t           flags_in;
  logic [PIX_W-1:0] up_rd;
  logic [PIX_W-1:0] mid_rd;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_pix;
  flags_t           s1_flags;
  logic [COL_W-1:0] s1_addr;
  logic             s1_hit;
  logic [PIX_W-1:0] s1_fwd;
  logic             s2_valid;
  flags_t           s2_flags;
  logic             s3_valid;
  flags_t           s3_flags;

  logic             adv1;
  logic             adv2;
  logic             adv3;
  logic             ready1;
  logic             ready2;
  logic             ready3;

  col_t             new_col;
  col_t             cell_in [NUM_COLS];
  col_t             win     [NUM_COLS];
  logic [PIX_W-1:0] centre;
  logic [PIX_W-1:0] lap;

  // Pipeline flow: a beat that produces no result drops out without waiting.
  assign adv3     = s3_valid && (!s3_flags.emit || !out_valid || !out_stall);
  assign ready3   = !s3_valid || adv3;
  assign adv2     = s2_valid && ready3;
  assign ready2   = !s2_valid || adv2;
  assign adv1     = s1_valid && ready2;
  assign ready1   = !s1_valid || adv1;
  assign in_stall = !ready1;
  assign in_acc   = in_valid && ready1;

  // A flush beat counts as a zero pixel.
  assign pix = padding ? '0 : gray_in;

  // Result status from the position of the incoming beat.
  assign flags_in.emit   = !((row_cnt == '0) || ((row_cnt == ROW_W'(1)) && (col_cnt == '0)));
  assign flags_in.border = (col_cnt == '0) || (col_cnt == COL_W'(1)) ||
                           (row_cnt == ROW_W'(1)) || (row_cnt == ROW_W'(img_h));
  assign flags_in.last   = (col_cnt == '0) && (row_cnt == ROW_W'(img_h) + ROW_W'(1));

  // Frame size registers and frame position.
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w   <= sat_dim(WIDTH_RESET, DIM_W'(MAX_WIDTH));
      img_h   <= sat_dim(HEIGHT_RESET, DIM_W'(MAX_HEIGHT));
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (cfg_we && (cfg_index inside {REG_WIDTH, REG_HEIGHT})) begin
      case (cfg_index)
        REG_WIDTH: begin
          img_w   <= sat_dim(cfg_data, DIM_W'(MAX_WIDTH));
          col_cnt <= '0;
          row_cnt <= '0;
        end
        REG_HEIGHT: begin
          img_h   <= sat_dim(cfg_data, DIM_W'(MAX_HEIGHT));
          col_cnt <= '0;
          row_cnt <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_acc) begin
      if (row_cnt >= ROW_W'(img_h) + ROW_W'(1)) begin
        col_cnt <= '0;
        row_cnt <= '0;
      end else if (DIM_W'(col_cnt) + DIM_W'(1) >= img_w) begin
        col_cnt <= '0;
        row_cnt <= row_cnt + ROW_W'(1);
      end else begin
        col_cnt <= col_cnt + COL_W'(1);
      end
    end
  end

  // Line store for the row two above; written as the beat leaves stage one.
  lef_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (adv1),
    .waddr (s1_addr),
    .wdata (mid_rd),
    .re    (in_acc),
    .raddr (col_cnt),
    .rdata (up_rd)
  );

  // Line store for the row above; written as the beat is taken.
  lef_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (in_acc),
    .waddr (col_cnt),
    .wdata (pix),
    .re    (in_acc),
    .raddr (col_cnt),
    .rdata (mid_rd)
  );

  // Stage one: line store reads in flight. A read of the address that the
  // previous beat writes in the same cycle takes the written value instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready1) begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix   <= pix;
      s1_flags <= flags_in;
      s1_addr  <= col_cnt;
      s1_hit   <= adv1 && (s1_addr == col_cnt);
      s1_fwd   <= mid_rd;
    end
  end

  // Window: three column cells, newest column in cell zero.
  assign new_col.top = s1_hit ? s1_fwd : up_rd;
  assign new_col.mid = mid_rd;
  assign new_col.bot = s1_pix;
  assign cell_in[0]  = new_col;

  for (genvar k = 0; k < NUM_COLS; k++) begin : g_cells
    if (k > 0) begin : g_link
      assign cell_in[k] = win[k-1];
    end
    lef_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .shift  (adv1),
      .col_in (cell_in[k]),
      .col    (win[k])
    );
  end

  // Stages two and three: window held, then partial sums held.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (ready2) begin
        s2_valid <= adv1;
      end
      if (ready3) begin
        s3_valid <= adv2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_flags <= s1_flags;
    end
    if (adv2) begin
      s3_flags <= s2_flags;
    end
  end

  lef_kernel u_kernel (
    .clk    (clk),
    .load   (adv2),
    .win    (win),
    .centre (centre),
    .lap    (lap)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv3 && s3_flags.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && s3_flags.emit) begin
      edge_out   <= s3_flags.border ? centre : lap;
      on_border  <= s3_flags.border;
      frame_last <= s3_flags.last;
    end
  end

  // The final pixel of a frame is a corner, hence on the border.
  a_last_border : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!frame_last || on_border))
    else $error("frame_last result not marked as border");

  // The input side only waits while stage one holds a beat.
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with stage one empty");

  // The column position stays inside the row.
  a_col_range : assert property (@(posedge clk) disable iff (rst)
    DIM_W'(col_cnt) < img_w)
    else $error("column position beyond image width");

  // The row position never runs past the flush row.
  a_row_range : assert property (@(posedge clk) disable iff (rst)
    row_cnt <= ROW_W'(img_h) + ROW_W'(1))
    else $error("row position beyond flush row");

endmodule
